// ----- rtl/tcf_pkg.sv -----
// Shared constants, handshake structs and helper functions for the tilt filter.
package tcf_pkg;

   localparam int CAL_SAMPLES = 500;
   localparam int ACC_LIMIT   = 8200;
   localparam int CAL_W       = $clog2(CAL_SAMPLES + 1);
   localparam int MAG_W       = 15;

   localparam logic [MAG_W-1:0]   ACC_LIMIT_V = MAG_W'(ACC_LIMIT);
   localparam logic signed [16:0] LIM_POS     = 17'(ACC_LIMIT);
   localparam logic signed [16:0] LIM_NEG     = 17'(-ACC_LIMIT);

   // Q0.30 coefficients KEEP_K and MIX_K; GYRO_K is scaled by 2^10
   localparam logic [16:0] GYRO_K = 17'd33286;
   localparam logic [29:0] KEEP_K = 30'd1073312327;
   localparam logic [18:0] MIX_K  = 19'd429497;

   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] ONE_Q30     = 31'd1073741824;
   localparam logic [26:0] DEG_MAX_Q20 = 27'd94371840;
   localparam logic [15:0] DEG_SCALE   = 16'd57296;
   localparam logic [18:0] DEG_ROUND   = 19'd512000;

   // serial divider geometry
   localparam int DIV_W   = 48;
   localparam int DSR_W   = 20;
   localparam int SHORT_W = 32;

   localparam logic [DSR_W-1:0] DEG_DIV = 20'd1024000;

   typedef struct packed {
      logic             start;
      logic             short_op;
      logic [DIV_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   // Taylor denominators (2k)(2k+1); k runs 7 down to 1
   function automatic logic [7:0] horner_div(input logic [2:0] k);
      logic [7:0] d;
      case (k)
         3'd7: d = 8'd210;
         3'd6: d = 8'd156;
         3'd5: d = 8'd110;
         3'd4: d = 8'd72;
         3'd3: d = 8'd42;
         3'd2: d = 8'd20;
         default: d = 8'd6;
      endcase
      return d;
   endfunction

   function automatic logic signed [16:0] sat17(input logic signed [27:0] v);
      logic signed [16:0] r;
      if (v > 28'sd65535) begin
         r = 17'sd65535;
      end else if (v < -28'sd65536) begin
         r = -17'sd65536;
      end else begin
         r = v[16:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -35'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/tcf_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module tcf_div (
   input  logic                clock,
   input  logic                reset,
   input  tcf_pkg::div_req_type req,
   output tcf_pkg::div_rsp_type rsp
);

   logic                              busy_ff;
   logic                              done_ff;
   logic                              short_ff;
   logic [5:0]                        cnt_ff;
   logic [tcf_pkg::DIV_W-1:0]         sh_ff;
   logic [tcf_pkg::DSR_W-1:0]         rem_ff;
   logic [tcf_pkg::DSR_W-1:0]         dsr_ff;
   logic [tcf_pkg::DSR_W:0]           trial;
   logic [tcf_pkg::DSR_W:0]           diff;
   logic                              fits;

   assign trial = {rem_ff, sh_ff[tcf_pkg::DIV_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !req.start && busy_ff && (cnt_ff == 6'd1);
         if (req.start) begin
            busy_ff  <= 1'b1;
            short_ff <= req.short_op;
            rem_ff   <= '0;
            dsr_ff   <= req.divisor;
            if (req.short_op) begin
               sh_ff  <= {req.dividend[tcf_pkg::SHORT_W-1:0],
                          {(tcf_pkg::DIV_W-tcf_pkg::SHORT_W){1'b0}}};
               cnt_ff <= 6'(tcf_pkg::SHORT_W);
            end else begin
               sh_ff  <= req.dividend;
               cnt_ff <= 6'(tcf_pkg::DIV_W);
            end
         end else if (busy_ff) begin
            sh_ff  <= {sh_ff[tcf_pkg::DIV_W-2:0], fits};
            rem_ff <= fits ? diff[tcf_pkg::DSR_W-1:0] : trial[tcf_pkg::DSR_W-1:0];
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = short_ff
      ? {{(tcf_pkg::DIV_W-tcf_pkg::SHORT_W){1'b0}}, sh_ff[tcf_pkg::SHORT_W-1:0]}
      : sh_ff;

endmodule

// ----- rtl/tcf_asin.sv -----
// Arcsine in degrees: bitwise search over theta with a Horner sine series.
module tcf_asin (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tcf_pkg::MAG_W-1:0]  mag,
   output logic                       done,
   output logic [26:0]                deg,
   output tcf_pkg::div_req_type       div_req,
   input  tcf_pkg::div_rsp_type       div_rsp
);

   typedef enum logic [3:0] {
      A_IDLE, A_BIT, A_MUL, A_DIV, A_DWAIT, A_SIN, A_CMP, A_DEG, A_DDIV, A_DDWAIT
   } asin_state_type;

   asin_state_type                state_ff;
   logic [4:0]                    bit_ff;
   logic [2:0]                    k_ff;
   logic [30:0]                   th_ff;
   logic [30:0]                   acc_ff;
   logic [31:0]                   t2_ff;
   logic [62:0]                   prod_ff;
   logic [30:0]                   sin_ff;
   logic [tcf_pkg::MAG_W+29:0]    target_ff;
   logic [47:0]                   dprod_ff;
   logic [26:0]                   deg_ff;
   logic                          done_ff;

   logic [30:0] cand;
   logic [61:0] sq;
   logic [62:0] hp;
   logic [61:0] sn;
   logic [45:0] lhs;
   logic [47:0] dprod_in;

   assign cand     = th_ff | (31'd1 << bit_ff);
   assign sq       = {31'b0, cand} * {31'b0, cand};
   assign hp       = {31'b0, t2_ff} * {32'b0, acc_ff};
   assign sn       = {31'b0, cand} * {31'b0, acc_ff};
   assign lhs      = {15'b0, sin_ff} * {31'b0, tcf_pkg::ACC_LIMIT_V};
   assign dprod_in = {17'b0, th_ff} * {32'b0, tcf_pkg::DEG_SCALE} + 48'(tcf_pkg::DEG_ROUND);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == A_DDWAIT) && div_rsp.done;
         case (state_ff)
            A_IDLE: begin
               if (start) begin
                  target_ff <= {mag, 30'b0};
                  th_ff     <= '0;
                  bit_ff    <= 5'd30;
                  state_ff  <= A_BIT;
               end
            end
            A_BIT: begin
               if (cand <= tcf_pkg::HALF_PI_Q30) begin
                  t2_ff    <= sq[61:30];
                  acc_ff   <= tcf_pkg::ONE_Q30;
                  k_ff     <= 3'd7;
                  state_ff <= A_MUL;
               end else if (bit_ff == 5'd0) begin
                  state_ff <= A_DEG;
               end else begin
                  bit_ff <= bit_ff - 5'd1;
               end
            end
            A_MUL: begin
               prod_ff  <= hp;
               state_ff <= A_DIV;
            end
            A_DIV: begin
               state_ff <= A_DWAIT;
            end
            A_DWAIT: begin
               if (div_rsp.done) begin
                  acc_ff <= tcf_pkg::ONE_Q30 - div_rsp.quotient[30:0];
                  if (k_ff == 3'd1) begin
                     state_ff <= A_SIN;
                  end else begin
                     k_ff     <= k_ff - 3'd1;
                     state_ff <= A_MUL;
                  end
               end
            end
            A_SIN: begin
               sin_ff   <= sn[60:30];
               state_ff <= A_CMP;
            end
            A_CMP: begin
               if (lhs <= {1'b0, target_ff}) begin
                  th_ff <= cand;
               end
               if (bit_ff == 5'd0) begin
                  state_ff <= A_DEG;
               end else begin
                  bit_ff   <= bit_ff - 5'd1;
                  state_ff <= A_BIT;
               end
            end
            A_DEG: begin
               dprod_ff <= dprod_in;
               state_ff <= A_DDIV;
            end
            A_DDIV: begin
               state_ff <= A_DDWAIT;
            end
            A_DDWAIT: begin
               if (div_rsp.done) begin
                  if (div_rsp.quotient > 48'(tcf_pkg::DEG_MAX_Q20)) begin
                     deg_ff <= tcf_pkg::DEG_MAX_Q20;
                  end else begin
                     deg_ff <= div_rsp.quotient[26:0];
                  end
                  state_ff <= A_IDLE;
               end
            end
            default: state_ff <= A_IDLE;
         endcase
      end
   end

   // Horner quotient fits in 32 bits, so the short divide serves it
   always_comb begin
      div_req.start    = (state_ff == A_DIV) || (state_ff == A_DDIV);
      div_req.short_op = (state_ff == A_DIV);
      if (state_ff == A_DIV) begin
         div_req.dividend = {16'b0, prod_ff[61:30]};
         div_req.divisor  = tcf_pkg::DSR_W'(tcf_pkg::horner_div(k_ff));
      end else begin
         div_req.dividend = dprod_ff;
         div_req.divisor  = tcf_pkg::DEG_DIV;
      end
   end

   assign done = done_ff;
   assign deg  = deg_ff;

endmodule

// ----- rtl/tilt_complementary_filter.sv -----
// Top level: gyro calibration, accelerometer arcsine and complementary blend.
// One transaction at a time. A calibration transaction adds one sample to the sums,
// and the one that ends a run also runs two short serial divides for the offsets.
// A measurement runs 31 arcsine search steps, each with seven Horner divides through
// the shared bit-serial divider when its candidate lies within pi/2, then a full-width degree divide.
// A new request is taken as soon as the previous result sits in the output register.
// Synchronous reset clears offsets, sums, the angle and the seeded flag.
module tilt_complementary_filter (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic signed [15:0] req_accel_raw,
   input  logic signed [15:0] req_gyro_pitch_raw,
   input  logic signed [15:0] req_gyro_yaw_raw,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_fused_angle,
   output logic signed [27:0] rsp_accel_angle,
   output logic signed [16:0] rsp_pitch_rate,
   output logic signed [16:0] rsp_yaw_rate,
   output logic signed [14:0] rsp_accel_clamped,
   output logic               rsp_calibrated,
   // accelerometer offset register
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic signed [15:0] csr_accel_offset
);

   typedef enum logic [3:0] {
      S_IDLE, S_CAL_SUM, S_CAL_DIVP, S_CAL_WAITP, S_CAL_DIVY, S_CAL_WAITY,
      S_MEAS_PREP, S_MEAS_ASIN, S_MEAS_WAIT, S_MEAS_GYRO, S_MEAS_SUM,
      S_MEAS_MUL, S_MEAS_ADD, S_MEAS_SAT, S_OUT
   } top_state_type;

   top_state_type state_ff;

   // latched request
   logic signed [15:0] acc_raw_ff;
   logic signed [15:0] gp_ff;
   logic signed [15:0] gy_ff;
   logic               meas_ff;

   // filter state
   logic [tcf_pkg::CAL_W-1:0] cal_count_ff;
   logic signed [26:0]        pitch_sum_ff;
   logic signed [26:0]        yaw_sum_ff;
   logic signed [16:0]        pitch_off_ff;
   logic signed [16:0]        yaw_off_ff;
   logic                      seeded_ff;
   logic signed [31:0]        angle_ff;
   logic signed [15:0]        accel_offset_ff;

   // working registers
   logic signed [15:0] aclamp_ff;
   logic signed [16:0] prate_ff;
   logic signed [16:0] yrate_ff;
   logic signed [27:0] aang_ff;
   logic signed [34:0] gprod_ff;
   logic signed [33:0] sum_ff;
   logic signed [64:0] keep_ff;
   logic signed [47:0] mix_ff;
   logic signed [34:0] tot_ff;
   logic               cal_done_ff;

   // output register
   logic               rsp_valid_ff;
   logic signed [31:0] o_fused_ff;
   logic signed [27:0] o_aang_ff;
   logic signed [16:0] o_prate_ff;
   logic signed [16:0] o_yrate_ff;
   logic signed [14:0] o_aclamp_ff;
   logic               o_cal_ff;

   // combinational helpers
   logic signed [16:0]          aoff;
   logic signed [15:0]          aclamp_in;
   logic signed [15:0]          aclamp_neg;
   logic [tcf_pkg::MAG_W-1:0]   mag;
   logic signed [17:0]          pdiff;
   logic signed [17:0]          ydiff;
   logic signed [26:0]          pbase;
   logic signed [26:0]          ybase;
   logic signed [26:0]          pitch_sum_in;
   logic signed [26:0]          yaw_sum_in;
   logic [tcf_pkg::CAL_W-1:0]   count_in;
   logic signed [26:0]          div_src;
   logic signed [26:0]          div_src_neg;
   logic [26:0]                 div_mag;
   logic [27:0]                 cal_q;
   logic signed [27:0]          cal_q_signed;
   logic signed [34:0]          gprod_in;
   logic signed [31:0]          base;
   logic signed [24:0]          gstep;
   logic signed [33:0]          sum_in;
   logic signed [64:0]          keep_in;
   logic signed [47:0]          mix_in;
   logic signed [64:0]          tot_in;
   logic signed [27:0]          deg_ext;
   logic                        load_out;

   // shared divider and arcsine unit
   tcf_pkg::div_req_type div_req;
   tcf_pkg::div_req_type asin_div_req;
   tcf_pkg::div_req_type cal_div_req;
   tcf_pkg::div_rsp_type div_rsp;
   logic                 asin_done;
   logic [26:0]          asin_deg;

   tcf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   tcf_asin u_asin (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == S_MEAS_ASIN),
      .mag     (mag),
      .done    (asin_done),
      .deg     (asin_deg),
      .div_req (asin_div_req),
      .div_rsp (div_rsp)
   );

   // accelerometer path: offset, clamp, magnitude
   assign aoff       = 17'(acc_raw_ff) + 17'(accel_offset_ff);
   assign aclamp_in  = (aoff > tcf_pkg::LIM_POS) ? 16'(tcf_pkg::LIM_POS) :
                       (aoff < tcf_pkg::LIM_NEG) ? 16'(tcf_pkg::LIM_NEG) : aoff[15:0];
   assign aclamp_neg = -aclamp_ff;
   assign mag        = aclamp_ff[15] ? aclamp_neg[tcf_pkg::MAG_W-1:0]
                                     : aclamp_ff[tcf_pkg::MAG_W-1:0];

   // rates after offset removal
   assign pdiff = 18'(gp_ff) - 18'(pitch_off_ff);
   assign ydiff = 18'(gy_ff) - 18'(yaw_off_ff);

   // calibration sums; a new run starts from the current offsets
   assign pbase        = (cal_count_ff == '0) ? 27'(pitch_off_ff) : pitch_sum_ff;
   assign ybase        = (cal_count_ff == '0) ? 27'(yaw_off_ff) : yaw_sum_ff;
   assign pitch_sum_in = pbase + 27'(gp_ff);
   assign yaw_sum_in   = ybase + 27'(gy_ff);
   assign count_in     = cal_count_ff + 1'b1;

   // divide the magnitude, restore sign: truncation toward zero
   assign div_src      = (state_ff == S_CAL_DIVP || state_ff == S_CAL_WAITP)
                         ? pitch_sum_ff : yaw_sum_ff;
   assign div_src_neg  = -div_src;
   assign div_mag      = div_src[26] ? div_src_neg : div_src;
   assign cal_q        = {1'b0, div_rsp.quotient[26:0]};
   assign cal_q_signed = div_src[26] ? -$signed(cal_q) : $signed(cal_q);

   always_comb begin
      cal_div_req.start    = (state_ff == S_CAL_DIVP) || (state_ff == S_CAL_DIVY);
      cal_div_req.short_op = 1'b1;
      cal_div_req.dividend = tcf_pkg::DIV_W'(div_mag);
      cal_div_req.divisor  = tcf_pkg::DSR_W'(tcf_pkg::CAL_SAMPLES);
   end

   assign div_req = meas_ff ? asin_div_req : cal_div_req;

   // gyro integration and blend datapath
   assign gprod_in = prate_ff * $signed({1'b0, tcf_pkg::GYRO_K}) + 35'sd512;
   assign base     = seeded_ff ? angle_ff : 32'(aang_ff);
   assign gstep    = gprod_ff[34:10];
   assign sum_in   = base + gstep;
   assign keep_in  = sum_ff * $signed({1'b0, tcf_pkg::KEEP_K});
   assign mix_in   = aang_ff * $signed({1'b0, tcf_pkg::MIX_K});
   assign tot_in   = keep_ff + 65'(mix_ff) + 65'sd536870912;
   assign deg_ext  = $signed({1'b0, asin_deg});

   assign load_out  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == S_IDLE);

   // main sequencer with the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cal_count_ff <= '0;
         pitch_sum_ff <= '0;
         yaw_sum_ff   <= '0;
         pitch_off_ff <= '0;
         yaw_off_ff   <= '0;
         seeded_ff    <= 1'b0;
         angle_ff     <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !load_out) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  acc_raw_ff <= req_accel_raw;
                  gp_ff      <= req_gyro_pitch_raw;
                  gy_ff      <= req_gyro_yaw_raw;
                  meas_ff    <= req_type;
                  state_ff   <= req_type ? S_MEAS_PREP : S_CAL_SUM;
               end
            end
            S_CAL_SUM: begin
               pitch_sum_ff <= pitch_sum_in;
               yaw_sum_ff   <= yaw_sum_in;
               if (32'(count_in) >= 32'(tcf_pkg::CAL_SAMPLES)) begin
                  cal_count_ff <= '0;
                  cal_done_ff  <= 1'b1;
                  state_ff     <= S_CAL_DIVP;
               end else begin
                  cal_count_ff <= count_in;
                  cal_done_ff  <= 1'b0;
                  state_ff     <= S_OUT;
               end
            end
            S_CAL_DIVP: state_ff <= S_CAL_WAITP;
            S_CAL_WAITP: begin
               if (div_rsp.done) begin
                  pitch_off_ff <= tcf_pkg::sat17(cal_q_signed);
                  state_ff     <= S_CAL_DIVY;
               end
            end
            S_CAL_DIVY: state_ff <= S_CAL_WAITY;
            S_CAL_WAITY: begin
               if (div_rsp.done) begin
                  yaw_off_ff <= tcf_pkg::sat17(cal_q_signed);
                  state_ff   <= S_OUT;
               end
            end
            S_MEAS_PREP: begin
               aclamp_ff   <= aclamp_in;
               prate_ff    <= tcf_pkg::sat17(28'(pdiff));
               yrate_ff    <= tcf_pkg::sat17(28'(ydiff));
               cal_done_ff <= 1'b0;
               state_ff    <= S_MEAS_ASIN;
            end
            S_MEAS_ASIN: state_ff <= S_MEAS_WAIT;
            S_MEAS_WAIT: begin
               if (asin_done) begin
                  aang_ff  <= aclamp_ff[15] ? -deg_ext : deg_ext;
                  state_ff <= S_MEAS_GYRO;
               end
            end
            S_MEAS_GYRO: begin
               gprod_ff <= gprod_in;
               state_ff <= S_MEAS_SUM;
            end
            S_MEAS_SUM: begin
               sum_ff   <= sum_in;
               state_ff <= S_MEAS_MUL;
            end
            S_MEAS_MUL: begin
               keep_ff  <= keep_in;
               mix_ff   <= mix_in;
               state_ff <= S_MEAS_ADD;
            end
            S_MEAS_ADD: begin
               tot_ff   <= tot_in[64:30];
               state_ff <= S_MEAS_SAT;
            end
            S_MEAS_SAT: begin
               angle_ff  <= tcf_pkg::sat32(tot_ff);
               seeded_ff <= 1'b1;
               state_ff  <= S_OUT;
            end
            S_OUT: begin
               if (load_out) begin
                  rsp_valid_ff <= 1'b1;
                  o_fused_ff   <= angle_ff;
                  o_cal_ff     <= cal_done_ff;
                  if (meas_ff) begin
                     o_aang_ff   <= aang_ff;
                     o_prate_ff  <= prate_ff;
                     o_yrate_ff  <= yrate_ff;
                     o_aclamp_ff <= aclamp_ff[14:0];
                  end else begin
                     o_aang_ff   <= '0;
                     o_prate_ff  <= '0;
                     o_yrate_ff  <= '0;
                     o_aclamp_ff <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // offset register, written whenever a transaction arrives
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_offset_ff <= '0;
      end else if (csr_valid) begin
         accel_offset_ff <= csr_accel_offset;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fused_angle   = o_fused_ff;
   assign rsp_accel_angle   = o_aang_ff;
   assign rsp_pitch_rate    = o_prate_ff;
   assign rsp_yaw_rate      = o_yrate_ff;
   assign rsp_accel_clamped = o_aclamp_ff;
   assign rsp_calibrated    = o_cal_ff;

endmodule
